// File: sv/ple_pkg.sv
package ple_pkg;

  // Default configuration
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the stream payloads
  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_GRAB,
    S_SHIFT,
    S_FIN
  } ple_state_t;

endpackage

// File: sv/positional_list_engine_top.sv
// Error results pass from the input transfer through S_FIN to the output; read
//   passes through S_GRAB and S_FIN; insert and remove shift the entries between
//   position and count, one entry moved per cycle through the single read / single
//   write port of the entry memory. One request is handled at a time.
// A new request may be taken while the previous result waits on the output.
// Reset (rst_n, synchronous, active low) clears the count, the sequencer and
//   the output valid; the entry memory is not cleared and needs no sweep.
module positional_list_engine_top #(
  parameter int DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] opcode, [8:2] position, [40:9] value, [47:41] zero
  input  logic [ple_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [33:2] data_out, [40:34] count, [47:41] zero
  output logic [ple_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

  // Input field split
  logic [ple_pkg::OP_W-1:0]   in_opcode;
  logic [ple_pkg::POS_W-1:0]  in_position;
  logic [ple_pkg::VAL_W-1:0]  in_value;
  assign in_opcode   = in_tdata[1:0];
  assign in_position = in_tdata[8:2];
  assign in_value    = in_tdata[40:9];

  // Control state
  ple_pkg::ple_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             wpend_r, wpend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state
  logic [ple_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]      val_r, val_nxt;
  logic [ple_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [ple_pkg::VAL_W-1:0]  data_r, data_nxt;
  logic [AW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]              wa_r, wa_nxt;
  logic [ple_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [ple_pkg::VAL_W-1:0]  out_data_r, out_data_nxt;
  logic [ple_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // Memory ports
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [AW-1:0]         mem_ra;

  // Width conversions
  logic [CW-1:0]                pos_w, cnt_w, new_cnt_w;
  logic signed [ple_pkg::VAL_W-1:0] in_val_s;
  logic [63:0]                  in_val_sx;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic [63:0]                  rd_sx;
  logic                         in_xfer;
  logic                         out_free;
  logic [ple_pkg::STAT_W-1:0]   chk_stat;

  assign pos_w     = CW'(in_position);
  assign cnt_w     = CW'(cnt_r);
  assign new_cnt_w = CW'(cnt_r);
  assign in_val_s  = in_value;
  assign in_val_sx = 64'(in_val_s);
  assign rd_s      = rd_data_r;
  assign rd_sx     = 64'(rd_s);

  assign in_tready  = (state_r == ple_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_data_r, out_status_r};

  // Request check against the current count
  always_comb begin
    chk_stat = ple_pkg::STAT_BADPOS;
    case (in_opcode)
      ple_pkg::OP_INSERT: begin
        if (pos_w > cnt_w) begin
          chk_stat = ple_pkg::STAT_BADPOS;
        end else if (cnt_w == CW'(DEPTH)) begin
          chk_stat = ple_pkg::STAT_FULL;
        end else begin
          chk_stat = ple_pkg::STAT_OK;
        end
      end
      ple_pkg::OP_REMOVE, ple_pkg::OP_READ: begin
        if (cnt_w == '0) begin
          chk_stat = ple_pkg::STAT_EMPTY;
        end else if (pos_w >= cnt_w) begin
          chk_stat = ple_pkg::STAT_BADPOS;
        end else begin
          chk_stat = ple_pkg::STAT_OK;
        end
      end
      default: chk_stat = ple_pkg::STAT_BADPOS;
    endcase
  end

  // Sequencer: next state, memory accesses and output load
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    wpend_nxt      = wpend_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    stat_nxt       = stat_r;
    data_nxt       = data_r;
    rd_idx_nxt     = rd_idx_r;
    wa_nxt         = wa_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = wa_r;
    mem_wd         = rd_data_r;
    mem_ra         = rd_idx_r;

    // result taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ple_pkg::S_IDLE: begin
        // read the named entry right away for remove and read
        mem_ra = pos_w[AW-1:0];
        if (in_xfer) begin
          op_nxt    = in_opcode;
          pos_nxt   = pos_w[AW-1:0];
          val_nxt   = in_val_sx[DATA_WIDTH-1:0];
          stat_nxt  = chk_stat;
          data_nxt  = '0;
          wpend_nxt = 1'b0;
          if (chk_stat != ple_pkg::STAT_OK) begin
            state_nxt = ple_pkg::S_FIN;
          end else if (in_opcode == ple_pkg::OP_INSERT) begin
            // move entries count-1 down to position one place up
            cnt_nxt    = cnt_r + 1'b1;
            rem_nxt    = CNT_W'(cnt_w - pos_w);
            rd_idx_nxt = AW'(cnt_w - 1'b1);
            state_nxt  = ple_pkg::S_INS;
          end else begin
            if (in_opcode == ple_pkg::OP_REMOVE) begin
              cnt_nxt = cnt_r - 1'b1;
            end
            rem_nxt    = CNT_W'(cnt_w - pos_w - 1'b1);
            rd_idx_nxt = AW'(pos_w + 1'b1);
            state_nxt  = ple_pkg::S_GRAB;
          end
        end
      end

      ple_pkg::S_INS: begin
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        if (rem_r != '0) begin
          wpend_nxt  = 1'b1;
          wa_nxt     = rd_idx_r + 1'b1;
          rd_idx_nxt = rd_idx_r - 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            // gap is open: drop the new value in
            mem_we    = 1'b1;
            mem_wa    = pos_r;
            mem_wd    = val_r;
            state_nxt = ple_pkg::S_FIN;
          end
        end
      end

      ple_pkg::S_GRAB: begin
        data_nxt = rd_sx[ple_pkg::VAL_W-1:0];
        if (op_r == ple_pkg::OP_REMOVE) begin
          state_nxt = ple_pkg::S_SHIFT;
        end else begin
          state_nxt = ple_pkg::S_FIN;
        end
      end

      ple_pkg::S_SHIFT: begin
        if (wpend_r) begin
          mem_we = 1'b1;
        end
        if (rem_r != '0) begin
          wpend_nxt  = 1'b1;
          wa_nxt     = rd_idx_r - 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            state_nxt = ple_pkg::S_FIN;
          end
        end
      end

      ple_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_data_nxt   = data_r;
          out_count_nxt  = new_cnt_w[ple_pkg::COUNT_W-1:0];
          state_nxt      = ple_pkg::S_IDLE;
        end
      end

      default: state_nxt = ple_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    stat_r       <= stat_nxt;
    data_r       <= data_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wa_r         <= wa_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && chk_stat == ple_pkg::STAT_OK && in_opcode == ple_pkg::OP_INSERT)
      |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not bump count");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::S_FIN && out_free) |=>
      (out_valid_r && state_r == ple_pkg::S_IDLE))
    else $error("finished result not loaded");
`endif

endmodule
